FILE: sv/mie_pkg.sv
// package: shared types, constants and microcode table for the modular inverse block
`timescale 1ns / 1ps

package mie_pkg;

    // datapath width follows the 32-bit value and modulus fields
    localparam int FIELD_W = 32;
    localparam int K_W     = $clog2(FIELD_W);
    localparam int PC_W    = 4;

    localparam logic [FIELD_W-1:0] RESET_MODULUS = 32'd988244353;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_ALIGN,
        OP_SUB,
        OP_INIT,
        OP_LOADDIV,
        OP_UPDATE,
        OP_FINISH,
        OP_FAIL
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_FIRE,
        C_N_ZERO,
        C_CAN_ALIGN,
        C_K_NZ,
        C_R1_ZERO,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } uword_t;

    // flags from the datapath to the sequencer
    typedef struct packed {
        logic in_fire;
        logic n_zero;
        logic can_align;
        logic k_nz;
        logic r1_zero;
        logic out_busy;
    } dp_status_t;

    // control from the sequencer to the datapath
    typedef struct packed {
        op_t  op;
        logic idle;
    } seq_ctrl_t;

    // step addresses
    localparam logic [PC_W-1:0] A_IDLE    = 4'd0;
    localparam logic [PC_W-1:0] A_CHK     = 4'd1;
    localparam logic [PC_W-1:0] A_ALIGN0  = 4'd2;
    localparam logic [PC_W-1:0] A_SUB0    = 4'd3;
    localparam logic [PC_W-1:0] A_INIT    = 4'd4;
    localparam logic [PC_W-1:0] A_TEST    = 4'd5;
    localparam logic [PC_W-1:0] A_LOADDIV = 4'd6;
    localparam logic [PC_W-1:0] A_ALIGN1  = 4'd7;
    localparam logic [PC_W-1:0] A_SUB1    = 4'd8;
    localparam logic [PC_W-1:0] A_UPDATE  = 4'd9;
    localparam logic [PC_W-1:0] A_FINISH  = 4'd10;
    localparam logic [PC_W-1:0] A_RET0    = 4'd11;
    localparam logic [PC_W-1:0] A_FAIL    = 4'd12;
    localparam logic [PC_W-1:0] A_RET1    = 4'd13;

    // microcode rom: taken jump goes to target, otherwise fall through
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        begin
            w = '{op: OP_NOP, cond: C_ALWAYS, target: A_IDLE};
            unique case (pc)
                A_IDLE:    w = '{op: OP_LOAD,    cond: C_NO_FIRE,   target: A_IDLE};
                A_CHK:     w = '{op: OP_NOP,     cond: C_N_ZERO,    target: A_FAIL};
                A_ALIGN0:  w = '{op: OP_ALIGN,   cond: C_CAN_ALIGN, target: A_ALIGN0};
                A_SUB0:    w = '{op: OP_SUB,     cond: C_K_NZ,      target: A_SUB0};
                A_INIT:    w = '{op: OP_INIT,    cond: C_NEVER,     target: A_IDLE};
                A_TEST:    w = '{op: OP_NOP,     cond: C_R1_ZERO,   target: A_FINISH};
                A_LOADDIV: w = '{op: OP_LOADDIV, cond: C_NEVER,     target: A_IDLE};
                A_ALIGN1:  w = '{op: OP_ALIGN,   cond: C_CAN_ALIGN, target: A_ALIGN1};
                A_SUB1:    w = '{op: OP_SUB,     cond: C_K_NZ,      target: A_SUB1};
                A_UPDATE:  w = '{op: OP_UPDATE,  cond: C_ALWAYS,    target: A_TEST};
                A_FINISH:  w = '{op: OP_FINISH,  cond: C_OUT_BUSY,  target: A_FINISH};
                A_RET0:    w = '{op: OP_NOP,     cond: C_ALWAYS,    target: A_IDLE};
                A_FAIL:    w = '{op: OP_FAIL,    cond: C_OUT_BUSY,  target: A_FAIL};
                A_RET1:    w = '{op: OP_NOP,     cond: C_ALWAYS,    target: A_IDLE};
                default:   w = '{op: OP_NOP,     cond: C_ALWAYS,    target: A_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

FILE: sv/modular_inverse_ext_euclid.sv
// Modular inverse by the extended Euclidean algorithm. Each accepted value gives one result:
// inverse = x in 0..modulus-1 with value*x == 1 mod modulus, and no_inverse = 1 (inverse 0)
// when gcd(value, modulus) is not 1 or the modulus is zero; a modulus of 1 gives 0. Only the
// low WIDTH bits of value and of a written modulus are used. One item is worked at a time by a
// microcoded shift-subtract divider: each quotient first aligns the divisor bit by bit, then
// subtracts one quotient bit per step, and each Euclid round adds a test, a divider load and an
// update step. The result sits in an output register, so the next value is taken while it
// waits. The user must write the modulus through modulus_we only while the block is idle; the
// block itself does not enforce this.
`timescale 1ns / 1ps

module modular_inverse_ext_euclid #(
    parameter int WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       modulus_we,
    input  logic [mie_pkg::FIELD_W-1:0] modulus,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [mie_pkg::FIELD_W-1:0] value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [mie_pkg::FIELD_W-1:0] inverse,
    output logic                       no_inverse
);
    import mie_pkg::*;

    localparam logic [FIELD_W-1:0] VMASK =
        (WIDTH >= FIELD_W) ? {FIELD_W{1'b1}} : ((FIELD_W'(1) << WIDTH) - FIELD_W'(1));

    dp_status_t status;
    seq_ctrl_t  ctrl;

    logic [FIELD_W-1:0] modulus_reg;
    logic [FIELD_W-1:0] rem_reg, rem_next;
    logic [FIELD_W-1:0] ds_reg, ds_next;
    logic [FIELD_W-1:0] mm_reg, mm_next;
    logic [FIELD_W-1:0] acc_reg, acc_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [FIELD_W-1:0] r0_reg, r0_next;
    logic [FIELD_W-1:0] r1_reg, r1_next;
    logic [FIELD_W-1:0] m0_reg, m0_next;
    logic [FIELD_W-1:0] m1_reg, m1_next;
    logic               neg0_reg, neg0_next;
    logic               neg1_reg, neg1_next;
    logic               out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] inverse_reg, inverse_next;
    logic               no_inverse_reg, no_inverse_next;

    logic [FIELD_W-1:0] ds_shl;
    logic               can_align;
    logic               can_sub;
    logic               in_fire;
    logic               out_busy;
    logic [FIELD_W-1:0] x_red;
    logic [FIELD_W-1:0] x_fin;

    // sequencer
    mie_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // handshake
    assign in_ready = ctrl.idle;
    assign in_fire  = in_valid && in_ready;
    assign out_busy = out_valid_reg && !out_ready;

    // divider compares
    assign ds_shl    = {ds_reg[FIELD_W-2:0], 1'b0};
    assign can_align = !ds_reg[FIELD_W-1] && (ds_shl <= rem_reg);
    assign can_sub   = (ds_reg <= rem_reg);

    // final coefficient folded into 0..n-1, then sign applied
    assign x_red = (m0_reg >= modulus_reg) ? (m0_reg - modulus_reg) : m0_reg;
    assign x_fin = (neg0_reg && (x_red != '0)) ? (modulus_reg - x_red) : x_red;

    assign status.in_fire   = in_fire;
    assign status.n_zero    = (modulus_reg == '0);
    assign status.can_align = can_align;
    assign status.k_nz      = (k_reg != '0);
    assign status.r1_zero   = (r1_reg == '0);
    assign status.out_busy  = out_busy;

    // datapath next state
    always_comb
    begin
        rem_next        = rem_reg;
        ds_next         = ds_reg;
        mm_next         = mm_reg;
        acc_next        = acc_reg;
        k_next          = k_reg;
        r0_next         = r0_reg;
        r1_next         = r1_reg;
        m0_next         = m0_reg;
        m1_next         = m1_reg;
        neg0_next       = neg0_reg;
        neg1_next       = neg1_reg;
        inverse_next    = inverse_reg;
        no_inverse_next = no_inverse_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        unique case (ctrl.op)
            OP_NOP:
            begin
            end
            // reduce value modulo n first
            OP_LOAD:
            begin
                if (in_fire)
                begin
                    rem_next = value & VMASK;
                    ds_next  = modulus_reg;
                    mm_next  = '0;
                    acc_next = '0;
                    k_next   = '0;
                end
            end
            // shift divisor and coefficient up to the top quotient bit
            OP_ALIGN:
            begin
                if (can_align)
                begin
                    ds_next = ds_shl;
                    mm_next = {mm_reg[FIELD_W-2:0], 1'b0};
                    k_next  = k_reg + 1'b1;
                end
            end
            // one quotient bit: subtract divisor from remainder, add coefficient
            OP_SUB:
            begin
                if (can_sub)
                begin
                    rem_next = rem_reg - ds_reg;
                    acc_next = acc_reg + mm_reg;
                end
                ds_next = {1'b0, ds_reg[FIELD_W-1:1]};
                mm_next = {1'b0, mm_reg[FIELD_W-1:1]};
                k_next  = k_reg - 1'b1;
            end
            OP_INIT:
            begin
                r0_next   = modulus_reg;
                r1_next   = rem_reg;
                m0_next   = '0;
                m1_next   = FIELD_W'(1);
                neg0_next = 1'b0;
                neg1_next = 1'b0;
            end
            OP_LOADDIV:
            begin
                rem_next = r0_reg;
                ds_next  = r1_reg;
                mm_next  = m1_reg;
                acc_next = m0_reg;
                k_next   = '0;
            end
            // advance the remainder sequence
            OP_UPDATE:
            begin
                r0_next   = r1_reg;
                r1_next   = rem_reg;
                m0_next   = m1_reg;
                m1_next   = acc_reg;
                neg0_next = neg1_reg;
                neg1_next = !neg1_reg;
            end
            OP_FINISH:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    if (r0_reg == FIELD_W'(1))
                    begin
                        inverse_next    = x_fin;
                        no_inverse_next = 1'b0;
                    end
                    else
                    begin
                        inverse_next    = '0;
                        no_inverse_next = 1'b1;
                    end
                end
            end
            OP_FAIL:
            begin
                if (!out_busy)
                begin
                    out_valid_next  = 1'b1;
                    inverse_next    = '0;
                    no_inverse_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= RESET_MODULUS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (modulus_we)
            begin
                modulus_reg <= modulus & VMASK;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rem_reg        <= rem_next;
        ds_reg         <= ds_next;
        mm_reg         <= mm_next;
        acc_reg        <= acc_next;
        k_reg          <= k_next;
        r0_reg         <= r0_next;
        r1_reg         <= r1_next;
        m0_reg         <= m0_next;
        m1_reg         <= m1_next;
        neg0_reg       <= neg0_next;
        neg1_reg       <= neg1_next;
        inverse_reg    <= inverse_next;
        no_inverse_reg <= no_inverse_next;
    end

    assign out_valid  = out_valid_reg;
    assign inverse    = inverse_reg;
    assign no_inverse = no_inverse_reg;

`ifndef SYNTHESIS
    // a new result beat comes only from a finishing step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !(out_valid_reg && !out_ready))
        |-> (ctrl.op == OP_FINISH || ctrl.op == OP_FAIL))
        else $error("result raised outside a finishing step");

    // a failed inverse carries a zero value
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_inverse) |-> (inverse == '0))
        else $error("no_inverse beat with nonzero inverse");

    // a found inverse lies below the modulus
    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !no_inverse) |-> (inverse < modulus_reg))
        else $error("inverse not reduced below modulus");

    // once a value is taken, the sequencer leaves the idle load step
    a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (ctrl.op != OP_LOAD))
        else $error("sequencer stayed idle after accepting a value");
`endif

endmodule

FILE: sv/mie_seq.sv
// step counter and microcode rom that drive the inverse datapath
`timescale 1ns / 1ps

module mie_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  mie_pkg::dp_status_t status,
    output mie_pkg::seq_ctrl_t  ctrl
);
    import mie_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          uw;
    logic            taken;

    // fetch the control word of this step
    assign uw = ucode(pc_reg);

    // evaluate the jump condition
    always_comb
    begin
        unique case (uw.cond)
            C_NEVER:     taken = 1'b0;
            C_ALWAYS:    taken = 1'b1;
            C_NO_FIRE:   taken = !status.in_fire;
            C_N_ZERO:    taken = status.n_zero;
            C_CAN_ALIGN: taken = status.can_align;
            C_K_NZ:      taken = status.k_nz;
            C_R1_ZERO:   taken = status.r1_zero;
            C_OUT_BUSY:  taken = status.out_busy;
            default:     taken = 1'b0;
        endcase
        pc_next = taken ? uw.target : pc_reg + 1'b1;
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= A_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.op   = uw.op;
    assign ctrl.idle = (pc_reg == A_IDLE);

endmodule
